### rtl/fcfa_pkg.sv
// Package for the fixed cell free list allocator: sizes, codes and shared types.
`default_nettype none
package fcfa_pkg;

    localparam int MAX_CELLS_PER_BLOCK = 64;
    localparam int MAX_BLOCKS          = 16;
    localparam int POOL_CELLS          = MAX_CELLS_PER_BLOCK * MAX_BLOCKS;

    localparam int OFF_W  = $clog2(MAX_CELLS_PER_BLOCK);
    localparam int BLK_W  = $clog2(MAX_BLOCKS);
    localparam int IDX_W  = 10;
    localparam int LINK_W = IDX_W + 1;
    localparam int BIU_W  = $clog2(MAX_BLOCKS + 1);
    localparam int CPB_W  = 7;
    localparam int LIM_W  = 5;
    localparam int CFG_W  = 7;
    localparam int CFG_AW = 1;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_CELLS);

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic [1:0] ST_GRANTED   = 2'd0;
    localparam logic [1:0] ST_RELEASED  = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_BAD_FREE  = 2'd3;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_CELLS_PER_BLOCK = 1'b0;
    localparam logic [CFG_AW-1:0] REG_BLOCK_LIMIT     = 1'b1;

    localparam logic [CPB_W-1:0] CPB_MIN   = CPB_W'(2);
    localparam logic [CPB_W-1:0] CPB_MAX   = CPB_W'(MAX_CELLS_PER_BLOCK);
    localparam logic [LIM_W-1:0] LIM_MIN   = LIM_W'(1);
    localparam logic [LIM_W-1:0] LIM_MAX   = LIM_W'(MAX_BLOCKS);

    typedef struct packed {
        logic [CPB_W-1:0] cells_per_block;
        logic [LIM_W-1:0] block_limit;
    } cfg_t;

endpackage
`default_nettype wire

### rtl/fcfa_cfg_regs.sv
// Configuration registers with range clamping for the allocator.
`default_nettype none
module fcfa_cfg_regs (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       cfg_wr_en,
    input  wire [fcfa_pkg::CFG_AW-1:0] cfg_index,
    input  wire [fcfa_pkg::CFG_W-1:0]  cfg_wdata,
    output fcfa_pkg::cfg_t            cfg
);
    import fcfa_pkg::*;

    logic [CPB_W-1:0] cpb_reg, cpb_next;
    logic [LIM_W-1:0] lim_reg, lim_next;
    logic [CPB_W-1:0] cpb_raw;
    logic [LIM_W-1:0] lim_raw;

    always_comb begin
        cpb_raw  = cfg_wdata[CPB_W-1:0];
        lim_raw  = cfg_wdata[LIM_W-1:0];
        cpb_next = cpb_reg;
        lim_next = lim_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_CELLS_PER_BLOCK: begin
                    if (cpb_raw < CPB_MIN)      cpb_next = CPB_MIN;
                    else if (cpb_raw > CPB_MAX) cpb_next = CPB_MAX;
                    else                        cpb_next = cpb_raw;
                end
                REG_BLOCK_LIMIT: begin
                    if (lim_raw < LIM_MIN)      lim_next = LIM_MIN;
                    else if (lim_raw > LIM_MAX) lim_next = LIM_MAX;
                    else                        lim_next = lim_raw;
                end
                default: begin
                    cpb_next = cpb_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpb_reg <= CPB_MAX;
            lim_reg <= LIM_MAX;
        end else begin
            cpb_reg <= cpb_next;
            lim_reg <= lim_next;
        end
    end

    assign cfg.cells_per_block = cpb_reg;
    assign cfg.block_limit     = lim_reg;

endmodule
`default_nettype wire

### rtl/fcfa_link_ram.sv
// Link memory: one write port, one registered read port.
`default_nettype none
module fcfa_link_ram (
    input  wire                        aclk,
    input  wire                        wr_en,
    input  wire [fcfa_pkg::IDX_W-1:0]  wr_addr,
    input  wire [fcfa_pkg::LINK_W-1:0] wr_data,
    input  wire [fcfa_pkg::IDX_W-1:0]  rd_addr,
    output logic [fcfa_pkg::LINK_W-1:0] rd_data
);
    import fcfa_pkg::*;

    logic [LINK_W-1:0] mem [POOL_CELLS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

### rtl/fixed_cell_free_list_allocator.sv
// Top level of the fixed cell free list allocator: command sequencer and result register.
//
//  channel   | ports        | beat contents
//  ----------+--------------+--------------------------------------------------
//  command   | s_axis_*     | tuser: command; tdata: cell_index (bits 9:0)
//  result    | m_axis_*     | tuser: status;  tdata: granted_index (bits 9:0)
//  config    | cfg_*        | index 0 cells_per_block, index 1 block_limit
//
//  A free is answered from S_IDLE, an alloc from the list passes through S_READ
//  (one link memory read). An alloc that brings in a new block passes through
//  S_FILL: the link memory write port initializes one cell per cycle.
//  Reset (aresetn low, synchronous) empties the list and clears the block count;
//  the link memory needs no clearing pass.
//  A command beat is taken whenever the sequencer is idle; a stalled result
//  holds in a pending slot and blocks only the following command.
`default_nettype none
module fixed_cell_free_list_allocator (
    input  wire                          aclk,
    input  wire                          aresetn,
    // command channel
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [15:0]                  s_axis_tdata,   // [9:0] cell_index
    input  wire                          s_axis_tuser,   // [0] command
    // result channel
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [15:0]                  m_axis_tdata,   // [9:0] granted_index
    output logic [1:0]                   m_axis_tuser,   // [1:0] status
    // configuration write port
    input  wire                          cfg_wr_en,
    input  wire  [fcfa_pkg::CFG_AW-1:0]  cfg_index,
    input  wire  [fcfa_pkg::CFG_W-1:0]   cfg_wdata
);
    import fcfa_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;   // wait for link of the head cell
    localparam logic [1:0] S_FILL = 2'd2;   // link cells of a new block
    localparam logic [1:0] S_HOLD = 2'd3;   // result waits for the output slot

    cfg_t cfg;

    logic [1:0]        state_reg, state_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [BIU_W-1:0]  biu_reg, biu_next;
    logic [OFF_W-1:0]  fill_off_reg, fill_off_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [IDX_W-1:0]  out_index_reg, out_index_next;
    logic [1:0]        pend_status_reg, pend_status_next;
    logic [IDX_W-1:0]  pend_index_reg, pend_index_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [LINK_W-1:0] mem_wdata;
    logic [LINK_W-1:0] mem_rdata;

    logic              emit;
    logic [1:0]        emit_status;
    logic [IDX_W-1:0]  emit_index;
    logic              out_free;
    logic              in_beat;

    logic [IDX_W-1:0]  req_idx;
    logic [BLK_W-1:0]  req_blk;
    logic [OFF_W-1:0]  req_off;
    logic              bad_free;
    logic [BLK_W-1:0]  fill_base;
    logic [CPB_W-1:0]  fill_off_ext;
    logic              fill_last;

    fcfa_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Read port always follows the list head; the read issued at the accept
    // edge returns the head's link in the next cycle, during S_READ.
    fcfa_link_ram u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (head_reg[IDX_W-1:0]),
        .rd_data (mem_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign req_idx   = s_axis_tdata[IDX_W-1:0];
    assign req_blk   = req_idx[IDX_W-1:OFF_W];
    assign req_off   = req_idx[OFF_W-1:0];
    assign bad_free  = (req_off == '0)
                    || ({1'b0, req_off} >= cfg.cells_per_block)
                    || (BIU_W'(req_blk) >= biu_reg);

    assign fill_base    = biu_reg[BLK_W-1:0];
    assign fill_off_ext = {1'b0, fill_off_reg};
    assign fill_last    = (fill_off_ext + CPB_W'(1)) >= cfg.cells_per_block;

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        biu_next      = biu_reg;
        fill_off_next = fill_off_reg;
        mem_we        = 1'b0;
        mem_waddr     = req_idx;
        mem_wdata     = head_reg;
        emit          = 1'b0;
        emit_status   = ST_GRANTED;
        emit_index    = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    if (s_axis_tuser == CMD_FREE) begin
                        emit = 1'b1;
                        if (bad_free) begin
                            emit_status = ST_BAD_FREE;
                        end else begin
                            // push: link the cell to the old head
                            mem_we      = 1'b1;
                            head_next   = {1'b0, req_idx};
                            emit_status = ST_RELEASED;
                        end
                    end else if (head_reg != NULL_LINK) begin
                        state_next = S_READ;
                    end else if (biu_reg < BIU_W'(cfg.block_limit)) begin
                        fill_off_next = OFF_W'(1);
                        state_next    = S_FILL;
                    end else begin
                        emit        = 1'b1;
                        emit_status = ST_EXHAUSTED;
                    end
                end
            end
            S_READ: begin
                // pop: the head's link becomes the new head
                emit        = 1'b1;
                emit_status = ST_GRANTED;
                emit_index  = head_reg[IDX_W-1:0];
                head_next   = mem_rdata;
                state_next  = S_IDLE;
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = {fill_base, fill_off_reg};
                if (fill_last) begin
                    mem_wdata = NULL_LINK;
                    // cell 1 goes out at once; its successor is cell 2 or nothing
                    biu_next  = biu_reg + BIU_W'(1);
                    if (cfg.cells_per_block == CPB_MIN) begin
                        head_next = NULL_LINK;
                    end else begin
                        head_next = {1'b0, fill_base, OFF_W'(2)};
                    end
                    emit        = 1'b1;
                    emit_status = ST_GRANTED;
                    emit_index  = {fill_base, OFF_W'(1)};
                    state_next  = S_IDLE;
                end else begin
                    mem_wdata     = {1'b0, fill_base, fill_off_reg + OFF_W'(1)};
                    fill_off_next = fill_off_reg + OFF_W'(1);
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result routing: straight into the output register when it is free,
    // otherwise park in the pending slot and hold the sequencer.
    always_comb begin
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_status_next  = out_status_reg;
        out_index_next   = out_index_reg;
        pend_status_next = pend_status_reg;
        pend_index_next  = pend_index_reg;
        if (state_reg == S_HOLD) begin
            if (out_free) begin
                out_valid_next  = 1'b1;
                out_status_next = pend_status_reg;
                out_index_next  = pend_index_reg;
            end
        end else if (emit) begin
            if (out_free) begin
                out_valid_next  = 1'b1;
                out_status_next = emit_status;
                out_index_next  = emit_index;
            end else begin
                pend_status_next = emit_status;
                pend_index_next  = emit_index;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= NULL_LINK;
            biu_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (emit && !out_free && state_reg != S_HOLD) begin
                state_reg <= S_HOLD;
            end else begin
                state_reg <= state_next;
            end
            head_reg      <= head_next;
            biu_reg       <= biu_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fill_off_reg    <= fill_off_next;
        out_status_reg  <= out_status_next;
        out_index_reg   <= out_index_next;
        pend_status_reg <= pend_status_next;
        pend_index_reg  <= pend_index_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {{(16 - IDX_W){1'b0}}, out_index_reg};

`ifndef SYNTHESIS
    // The list head never names a descriptor cell.
    a_head_not_descriptor: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg != NULL_LINK |-> head_reg[OFF_W-1:0] != '0)
        else $error("list head names a descriptor cell");

    // The list head lies inside a block already in use.
    a_head_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg != NULL_LINK |-> BIU_W'(head_reg[IDX_W-1:OFF_W]) < biu_reg)
        else $error("list head outside blocks in use");

    // A grant never hands out a descriptor cell.
    a_grant_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg == ST_GRANTED |-> out_index_reg[OFF_W-1:0] != '0)
        else $error("grant of a descriptor cell");

    // A result that is not a grant carries index zero.
    a_nongrant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg != ST_GRANTED |-> out_index_reg == '0)
        else $error("non-grant result with nonzero index");
`endif

endmodule
`default_nettype wire
